/* rtl/assert_macros.svh */
// assertion macros shared by the synthesizer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, ignored while reset is high, fixed message
`define PWS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pws assertion failed");

// clocked check, ignored while reset is high, caller message
`define PWS_ASSERT_MSG(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`endif

/* rtl/pws_pkg.sv */
// shared types, field widths and sine table helpers for the synthesizer
// no dependencies; used by the channel interfaces and the top level
package pws_pkg;

   localparam int CMD_W      = 2;
   localparam int NOTE_W     = 7;
   localparam int VEL_W      = 7;
   localparam int STEP_W     = 26;
   localparam int PHASE_W    = 26;
   localparam int SAMPLE_W   = 12;
   localparam int ROM_W      = 16;
   localparam int FRAC_SHIFT = 16;
   localparam int DAC_MID    = 2048;
   localparam int DAC_MAX    = 4095;

   localparam int VOICES_DEFAULT    = 15;
   localparam int TABLE_LEN_DEFAULT = 1000;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK     = 2'd0,
      CMD_NOTE_ON  = 2'd1,
      CMD_NOTE_OFF = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_ON_SCAN,
      ST_OFF_SCAN,
      ST_MIX,
      ST_DRAIN
   } state_type;

   // q62 fixed point constants for the table builder
   localparam logic [63:0] ONE_Q     = 64'h4000_0000_0000_0000;
   localparam logic [63:0] HALF_PI_Q = 64'h6487_ED51_10B4_611A;

   localparam int SERIES_TERMS = 16;

   // (k+1)(k+2) for the odd and even taylor series
   localparam logic [63:0] SIN_DIV [SERIES_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
      64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056
   };
   localparam logic [63:0] COS_DIV [SERIES_TERMS] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240,
      64'd306, 64'd380, 64'd462, 64'd552, 64'd650, 64'd756, 64'd870, 64'd992
   };

   // floor(a*b / 2^62), low 64 bits
   function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // taylor series in q62, odd selects sine, else cosine
   function automatic logic signed [63:0] series(input logic [63:0] a, input logic odd);
      logic [63:0]        a2;
      logic [63:0]        term;
      logic [63:0]        nxt;
      logic signed [63:0] sum;
      logic               neg;
      a2   = mul_q(a, a);
      term = odd ? a : ONE_Q;
      sum  = '0;
      neg  = 1'b0;
      for (int j = 0; j < SERIES_TERMS; j++) begin
         sum  = neg ? sum - $signed(term) : sum + $signed(term);
         neg  = !neg;
         nxt  = mul_q(term, a2);
         term = odd ? nxt / SIN_DIV[j] : nxt / COS_DIV[j];
      end
      return sum;
   endfunction

endpackage

/* rtl/pws_req_if.sv */
// request channel: command word with note, velocity and phase step
// depends on pws_pkg for field widths
interface pws_req_if;
   import pws_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [NOTE_W-1:0] note_key;
   logic [VEL_W-1:0]  velocity;
   logic [STEP_W-1:0] phase_step;

   modport source (output valid, output command, output note_key, output velocity,
                   output phase_step, input ready);
   modport sink   (input valid, input command, input note_key, input velocity,
                   input phase_step, output ready);
endinterface

/* rtl/pws_rsp_if.sv */
// response channel: one mixed dac sample word per tick
// depends on pws_pkg for field widths
interface pws_rsp_if;
   import pws_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] dac_sample;

   modport source (output valid, output dac_sample, input ready);
   modport sink   (input valid, input dac_sample, output ready);
endinterface

/* rtl/polyphonic_wavetable_synth.sv */
// Tick: mixes one voice per cycle through the sine ROM and the multiplier, then drains
// the ROM, multiply and accumulate registers; the sample is registered once the last
// sample is no longer waiting, and the next word is taken after that.
// Note on: subtracts TABLE_LEN<<16 from the step until it lies below that, then scans the
// voices; note off and zero-velocity note on: scan the voices. Unused command: no effect.
// Synchronous reset clears all voices and control; the ROM is constant.
`include "assert_macros.svh"

module polyphonic_wavetable_synth #(
   parameter int VOICES    = pws_pkg::VOICES_DEFAULT,
   parameter int TABLE_LEN = pws_pkg::TABLE_LEN_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   pws_req_if.sink      req_bus,
   pws_rsp_if.source    rsp_bus
);
   import pws_pkg::*;

   localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int ADDR_W = $clog2(TABLE_LEN);
   localparam int PROD_W = ROM_W + VEL_W;
   localparam int ACC_W  = PROD_W + $clog2(VOICES) + 1;
   localparam int MIX_W  = (ACC_W - 14 > 14) ? ACC_W - 14 : 14;

   localparam logic [PHASE_W:0] PHASE_MOD = (PHASE_W + 1)'(TABLE_LEN) << FRAC_SHIFT;
   localparam logic [63:0]      ROM_Q     = HALF_PI_Q / TABLE_LEN;
   localparam logic [63:0]      ROM_R     = HALF_PI_Q % TABLE_LEN;

   typedef logic [TABLE_LEN-1:0][ROM_W-1:0] rom_type;

   // trunc(32767*sin(2*pi*i/TABLE_LEN)) from the q62 series
   function automatic logic [ROM_W-1:0] sine_entry(input int unsigned i);
      logic [31:0]        four;
      logic [31:0]        quad;
      logic [31:0]        rem;
      logic [63:0]        a;
      logic signed [63:0] s;
      logic [63:0]        mag;
      four = 32'(4 * i);
      quad = four / TABLE_LEN;
      rem  = four % TABLE_LEN;
      a    = ROM_Q * 64'(rem) + (ROM_R * 64'(rem)) / TABLE_LEN;
      s    = series(a, quad[0] == 1'b0);
      mag  = (s > 0) ? mul_q(s, 64'd32767) : 64'd0;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      return (quad >= 32'd2) ? -mag[ROM_W-1:0] : mag[ROM_W-1:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i < TABLE_LEN; i++) begin
         r[i] = sine_entry(i);
      end
      return r;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // control
   state_type           state_ff, state_in;
   logic [VIDX_W-1:0]   vidx_ff, vidx_in;
   logic                on_act_ff, on_act_in;
   logic                s1_v_ff, s1_v_in;
   logic                s2_v_ff, s2_v_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // voice state
   logic [NOTE_W-1:0]   voice_note_ff [VOICES];
   logic [NOTE_W-1:0]   voice_note_in [VOICES];
   logic [VEL_W-1:0]    voice_volume_ff [VOICES];
   logic [VEL_W-1:0]    voice_volume_in [VOICES];
   logic [STEP_W-1:0]   voice_step_ff [VOICES];
   logic [STEP_W-1:0]   voice_step_in [VOICES];
   logic [PHASE_W-1:0]  voice_phase_ff [VOICES];
   logic [PHASE_W-1:0]  voice_phase_in [VOICES];
   logic [VOICES-1:0]   voice_act_ff, voice_act_in;

   // payload
   logic [NOTE_W-1:0]   key_ff, key_in;
   logic [VEL_W-1:0]    vel_ff, vel_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic signed [ROM_W-1:0]  rom_q_ff;
   logic [VEL_W-1:0]         vol_q_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [SAMPLE_W-1:0]      rsp_data_ff, rsp_data_in;

   // shared datapath
   logic                last_voice;
   logic                off_match;
   logic                emit;
   logic [ADDR_W-1:0]   rom_addr;
   logic [PHASE_W:0]    phase_sum;
   logic [PHASE_W:0]    phase_wrap;
   logic [PHASE_W:0]    step_diff;
   logic signed [ACC_W-17:0] mix_sh;
   logic signed [MIX_W-1:0]  mix_v;
   logic [SAMPLE_W-1:0]      mix_sample;

   assign last_voice = (vidx_ff == VIDX_W'(VOICES - 1));
   assign off_match  = voice_act_ff[vidx_ff] && (voice_note_ff[vidx_ff] == key_ff);
   assign emit       = (state_ff == ST_DRAIN) && !s1_v_ff && !s2_v_ff
                       && (!rsp_valid_ff || rsp_bus.ready);
   assign rom_addr   = voice_phase_ff[vidx_ff][FRAC_SHIFT +: ADDR_W];

   // phase stays below the table length, so one conditional subtract wraps it
   assign phase_sum  = {1'b0, voice_phase_ff[vidx_ff]} + {1'b0, voice_step_ff[vidx_ff]};
   assign phase_wrap = (phase_sum >= PHASE_MOD) ? phase_sum - PHASE_MOD : phase_sum;
   assign step_diff  = {1'b0, step_ff} - PHASE_MOD;

   assign mix_sh = acc_ff[ACC_W-1:FRAC_SHIFT];
   assign mix_v  = MIX_W'(mix_sh) + MIX_W'(DAC_MID);

   always_comb begin
      if (mix_v < 0) begin
         mix_sample = '0;
      end else if (mix_v > MIX_W'(DAC_MAX)) begin
         mix_sample = SAMPLE_W'(DAC_MAX);
      end else begin
         mix_sample = mix_v[SAMPLE_W-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               case (cmd_type'(req_bus.command))
                  CMD_TICK:     state_in = ST_MIX;
                  CMD_NOTE_ON:  state_in = (req_bus.velocity == '0) ? ST_OFF_SCAN : ST_REDUCE;
                  CMD_NOTE_OFF: state_in = ST_OFF_SCAN;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_REDUCE: begin
            if ({1'b0, step_ff} < PHASE_MOD) begin
               state_in = ST_ON_SCAN;
            end
         end
         ST_ON_SCAN: begin
            if (!voice_act_ff[vidx_ff] || last_voice) begin
               state_in = ST_IDLE;
            end
         end
         ST_OFF_SCAN: begin
            if (off_match || last_voice) begin
               state_in = ST_IDLE;
            end
         end
         ST_MIX: begin
            if (last_voice) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (emit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_bus.ready   = (state_ff == ST_IDLE);
      vidx_in         = vidx_ff;
      on_act_in       = on_act_ff;
      key_in          = key_ff;
      vel_in          = vel_ff;
      step_in         = step_ff;
      acc_in          = acc_ff;
      voice_note_in   = voice_note_ff;
      voice_volume_in = voice_volume_ff;
      voice_step_in   = voice_step_ff;
      voice_phase_in  = voice_phase_ff;
      voice_act_in    = voice_act_ff;
      s1_v_in         = (state_ff == ST_MIX);
      s2_v_in         = s1_v_ff;
      prod_in         = PROD_W'(rom_q_ff) * PROD_W'($signed({1'b0, vol_q_ff}));
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;

      if (s2_v_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               vidx_in   = '0;
               key_in    = req_bus.note_key;
               vel_in    = req_bus.velocity;
               step_in   = req_bus.phase_step;
               on_act_in = |req_bus.phase_step;
               acc_in    = '0;
            end
         end
         ST_REDUCE: begin
            if ({1'b0, step_ff} >= PHASE_MOD) begin
               step_in = step_diff[STEP_W-1:0];
            end
         end
         ST_ON_SCAN: begin
            if (!voice_act_ff[vidx_ff]) begin
               voice_note_in[vidx_ff]   = key_ff;
               voice_volume_in[vidx_ff] = vel_ff;
               voice_step_in[vidx_ff]   = step_ff;
               voice_act_in[vidx_ff]    = on_act_ff;
            end else if (!last_voice) begin
               vidx_in = vidx_ff + VIDX_W'(1);
            end
         end
         ST_OFF_SCAN: begin
            if (off_match) begin
               voice_note_in[vidx_ff]   = '0;
               voice_volume_in[vidx_ff] = '0;
               voice_step_in[vidx_ff]   = '0;
               voice_act_in[vidx_ff]    = 1'b0;
            end else if (!last_voice) begin
               vidx_in = vidx_ff + VIDX_W'(1);
            end
         end
         ST_MIX: begin
            voice_phase_in[vidx_ff] = phase_wrap[PHASE_W-1:0];
            if (!last_voice) begin
               vidx_in = vidx_ff + VIDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mix_sample;
            end
         end
         default: begin
         end
      endcase

      rsp_bus.valid      = rsp_valid_ff;
      rsp_bus.dac_sample = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         vidx_ff         <= '0;
         on_act_ff       <= 1'b0;
         s1_v_ff         <= 1'b0;
         s2_v_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         acc_ff          <= '0;
         voice_note_ff   <= '{default: '0};
         voice_volume_ff <= '{default: '0};
         voice_step_ff   <= '{default: '0};
         voice_phase_ff  <= '{default: '0};
         voice_act_ff    <= '0;
      end else begin
         state_ff        <= state_in;
         vidx_ff         <= vidx_in;
         on_act_ff       <= on_act_in;
         s1_v_ff         <= s1_v_in;
         s2_v_ff         <= s2_v_in;
         rsp_valid_ff    <= rsp_valid_in;
         acc_ff          <= acc_in;
         voice_note_ff   <= voice_note_in;
         voice_volume_ff <= voice_volume_in;
         voice_step_ff   <= voice_step_in;
         voice_phase_ff  <= voice_phase_in;
         voice_act_ff    <= voice_act_in;
      end
   end

   // rom read and multiply pipeline
   always_ff @(posedge clock) begin
      rom_q_ff    <= SINE_ROM[rom_addr];
      vol_q_ff    <= voice_volume_ff[vidx_ff];
      prod_ff     <= prod_in;
      key_ff      <= key_in;
      vel_ff      <= vel_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   `PWS_ASSERT(a_vidx_range, clock, reset, vidx_ff <= VIDX_W'(VOICES - 1))
   `PWS_ASSERT(a_phase_in_table, clock, reset,
      (state_ff == ST_MIX) |-> ({1'b0, voice_phase_ff[vidx_ff]} < PHASE_MOD))
   `PWS_ASSERT_MSG(a_pipe_order, clock, reset, s2_v_ff |-> $past(s1_v_ff),
      "multiply stage valid without rom stage")
   `PWS_ASSERT_MSG(a_rsp_from_drain, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DRAIN), "sample word outside drain")

endmodule

/* verif/tb_top.sv */
// self-checking bench for the polyphonic wavetable synth: drives command words,
// predicts each mixed sample from a voice model and checks the sample stream
// depends on pws_pkg, pws_req_if, pws_rsp_if and the polyphonic_wavetable_synth rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pws_pkg::*;

   localparam int          NUM_VOICES   = VOICES_DEFAULT;
   localparam int          WAVE_LEN     = TABLE_LEN_DEFAULT;
   localparam int unsigned PHASE_WRAP   = WAVE_LEN << FRAC_SHIFT;
   localparam int          RANDOM_WORDS = 2000;
   localparam int          DRAIN_CYCLES = 64;
   localparam int          STALL_LIMIT  = 2000;
   localparam int          PRINT_LIMIT  = 40;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [NOTE_W-1:0] note_key;
      logic [VEL_W-1:0]  velocity;
      logic [STEP_W-1:0] phase_step;
   } synth_word;

   logic clock;
   logic reset;

   pws_req_if req_bus ();
   pws_rsp_if rsp_bus ();

   polyphonic_wavetable_synth u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // voice model
   logic signed [ROM_W-1:0] sine_rom [WAVE_LEN];
   logic [NOTE_W-1:0]       v_note   [NUM_VOICES];
   logic [VEL_W-1:0]        v_vol    [NUM_VOICES];
   logic [STEP_W-1:0]       v_step   [NUM_VOICES];
   logic [PHASE_W-1:0]      v_phase  [NUM_VOICES];

   synth_word           pending_words [$];
   logic [SAMPLE_W-1:0] expected_samples [$];
   synth_word           on_bus;

   int          total_words;
   int          words_accepted;
   int          samples_checked;
   int          notes_loaded;
   int          notes_dropped;
   int          voices_released;
   int          mismatches;
   int          stall_cycles;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [NOTE_W-1:0] key,
                             input logic [VEL_W-1:0] vel, input logic [STEP_W-1:0] step);
      pending_words.push_back('{command: cmd, note_key: key, velocity: vel, phase_step: step});
   endtask

   // frees the first sounding voice on this key, phase is left alone
   task automatic release_voice(input logic [NOTE_W-1:0] key);
      for (int i = 0; i < NUM_VOICES; i++) begin
         if (v_step[i] != '0 && v_note[i] == key) begin
            v_step[i] = '0;
            v_note[i] = '0;
            v_vol[i]  = '0;
            voices_released++;
            return;
         end
      end
   endtask

   task automatic apply_word(input synth_word w);
      longint      acc;
      int          level;
      int          slot;
      int unsigned ph;
      case (w.command)
         CMD_TICK: begin
            acc = 0;
            for (int i = 0; i < NUM_VOICES; i++) begin
               ph = v_phase[i];
               acc += longint'(sine_rom[(ph % PHASE_WRAP) >> FRAC_SHIFT]) * longint'(v_vol[i]);
               v_phase[i] = PHASE_W'((ph + v_step[i]) % PHASE_WRAP);
            end
            // arithmetic shift floors negative mixes
            level = int'(acc >>> FRAC_SHIFT) + DAC_MID;
            if (level < 0)
               level = 0;
            if (level > DAC_MAX)
               level = DAC_MAX;
            expected_samples.push_back(SAMPLE_W'(level));
         end
         CMD_NOTE_ON: begin
            if (w.velocity == '0) begin
               release_voice(w.note_key);
            end else begin
               slot = -1;
               for (int i = 0; i < NUM_VOICES; i++)
                  if (slot < 0 && v_step[i] == '0)
                     slot = i;
               if (slot >= 0) begin
                  v_step[slot] = w.phase_step;
                  v_note[slot] = w.note_key;
                  v_vol[slot]  = w.velocity;
                  notes_loaded++;
               end else begin
                  notes_dropped++;
               end
            end
         end
         CMD_NOTE_OFF: begin
            release_voice(w.note_key);
         end
         default: begin
         end
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_word(on_bus);
            words_accepted++;
            if (words_accepted == total_words / 3) begin
               send_idle_pct <= 63;
               recv_idle_pct <= 20;
            end else if (words_accepted == 2 * total_words / 3) begin
               send_idle_pct <= 0;
               recv_idle_pct <= 0;
            end
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = pending_words.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.command    <= on_bus.command;
               req_bus.note_key   <= on_bus.note_key;
               req_bus.velocity   <= on_bus.velocity;
               req_bus.phase_step <= on_bus.phase_step;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            samples_checked++;
            if (expected_samples.size() == 0) begin
               report_mismatch($sformatf("sample word %0d with no tick pending",
                                         rsp_bus.dac_sample));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_bus.dac_sample !== want)
                  report_mismatch($sformatf("sample %0d: dac_sample %0d, expected %0d",
                                            samples_checked, rsp_bus.dac_sample, want));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("** polyphonic_wavetable_synth: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int               counted;
      int               phrase_kind;
      int               phrase_len;
      int               roll;
      int               quad;
      int               rem_q;
      int               mag;
      real              ang;
      real              s;
      logic [CMD_W-1:0]  cmd;
      logic [NOTE_W-1:0] key;
      logic [VEL_W-1:0]  vel;
      logic [STEP_W-1:0] step;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_TICK;
      req_bus.note_key   = '0;
      req_bus.velocity   = '0;
      req_bus.phase_step = '0;
      rsp_bus.ready      = 1'b0;
      send_idle_pct      = 20;
      recv_idle_pct      = 63;
      words_accepted     = 0;
      samples_checked    = 0;
      notes_loaded       = 0;
      notes_dropped      = 0;
      voices_released    = 0;
      mismatches         = 0;
      stall_cycles       = 0;

      for (int i = 0; i < NUM_VOICES; i++) begin
         v_note[i]  = '0;
         v_vol[i]   = '0;
         v_step[i]  = '0;
         v_phase[i] = '0;
      end

      // quarter-wave reduction keeps the zero crossings and peaks exact
      for (int i = 0; i < WAVE_LEN; i++) begin
         quad  = (4 * i) / WAVE_LEN;
         rem_q = (4 * i) % WAVE_LEN;
         ang   = 1.5707963267948966 * rem_q / WAVE_LEN;
         s     = (quad % 2 == 0) ? $sin(ang) : $cos(ang);
         mag   = (s > 0.0) ? $rtoi(32767.0 * s) : 0;
         if (mag > 32767)
            mag = 32767;
         sine_rom[i] = ROM_W'((quad >= 2) ? -mag : mag);
      end

      // directed words
      queue_word(CMD_TICK, 7'd0, 7'd0, '0);
      queue_word(CMD_NOTE_ON, 7'd127, 7'd127, 26'h3FF_FFFF);
      queue_word(CMD_NOTE_ON, 7'd0, 7'd1, 26'(PHASE_WRAP - 1));
      queue_word(CMD_NOTE_ON, 7'd42, 7'd100, '0);            // zero step, voice stays free
      queue_word(CMD_TICK, 7'd0, 7'd0, '0);
      queue_word(CMD_TICK, 7'd127, 7'd127, 26'h3FF_FFFF);
      queue_word(CMD_NOTE_ON, 7'd9, 7'd0, 26'd12345);         // release with no match
      queue_word(CMD_NOTE_OFF, 7'd42, 7'd0, '0);              // silent voice is not sounding
      queue_word(CMD_NOTE_ON, 7'd42, 7'd0, '0);
      queue_word(CMD_TICK, 7'd0, 7'd0, '0);
      queue_word(CMD_NOTE_ON, 7'd127, 7'd0, 26'h2AA_AAAA);   // zero velocity releases
      queue_word(CMD_NOTE_OFF, 7'd0, 7'd127, 26'h3FF_FFFF);
      queue_word(CMD_NOTE_OFF, 7'd77, 7'd0, '0);
      queue_word(CMD_UNUSED, 7'd127, 7'd127, 26'h3FF_FFFF);
      queue_word(CMD_TICK, 7'd0, 7'd0, '0);
      queue_word(CMD_NOTE_ON, 7'd85, 7'd85, 26'h155_5555);
      queue_word(CMD_NOTE_ON, 7'd42, 7'd127, 26'(PHASE_WRAP)); // full-turn step
      queue_word(CMD_NOTE_ON, 7'd43, 7'd64, 26'd65536);
      for (int i = 0; i < 4; i++)
         queue_word(CMD_TICK, 7'd0, 7'd0, '0);

      // random phrases: filling voices, releasing them, playing, and noise
      counted = 0;
      while (counted < RANDOM_WORDS) begin
         phrase_kind = $urandom_range(9);
         phrase_len  = $urandom_range(40, 4);
         for (int n = 0; n < phrase_len; n++) begin
            roll = $urandom_range(99);
            key  = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                             : 7'($urandom_range(75, 60));
            vel  = ($urandom_range(11) == 0) ? '0 : 7'($urandom_range(127, 1));
            case ($urandom_range(19))
               0, 1:    step = '0;
               2, 3:    step = 26'($urandom);
               4:       step = 26'h3FF_FFFF;
               5:       step = 26'(PHASE_WRAP - 1 + $urandom_range(2));
               default: step = 26'($urandom_range(3_300_000, 1));
            endcase
            if (phrase_kind < 3)
               cmd = (roll < 70) ? CMD_NOTE_ON : (roll < 80) ? CMD_NOTE_OFF : CMD_TICK;
            else if (phrase_kind < 5)
               cmd = (roll < 60) ? CMD_NOTE_OFF : (roll < 70) ? CMD_NOTE_ON : CMD_TICK;
            else if (phrase_kind < 9)
               cmd = (roll < 80) ? CMD_TICK : (roll < 90) ? CMD_NOTE_ON : CMD_NOTE_OFF;
            else
               cmd = CMD_W'($urandom_range(3));
            queue_word(cmd, key, vel, step);
            if (cmd != CMD_UNUSED)
               counted++;
         end
      end
      total_words = pending_words.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_bus.valid || expected_samples.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_samples.size() != 0)
         report_mismatch($sformatf("%0d samples never arrived", expected_samples.size()));

      $display("run covered %0d words, %0d samples checked, %0d note-ons loaded,",
               words_accepted, samples_checked, notes_loaded);
      $display("%0d note-ons dropped with every voice busy, %0d voices released, %0d mismatches",
               notes_dropped, voices_released, mismatches);
      if (mismatches == 0) begin
         $display("** polyphonic_wavetable_synth: PASSED **");
      end else begin
         $display("** polyphonic_wavetable_synth: FAILED **");
      end
      $finish;
   end

endmodule
